@@ rtl/core/rtc_alarm_countdown_assert.svh @@
// ----------------------------------------------------------------------------
// rtc_alarm_countdown_assert: assertion macros for the alarm countdown block.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef RTC_ALARM_COUNTDOWN_ASSERT_SVH
`define RTC_ALARM_COUNTDOWN_ASSERT_SVH

// Same-cycle implication.
`define RAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rac_pkg.sv @@
// ----------------------------------------------------------------------------
// rac_pkg: shared types, constants and decode functions.
// Holds the stage payload types and the alarm byte decoding.
// ----------------------------------------------------------------------------
package rac_pkg;

    localparam int SecW   = 6;
    localparam int MinW   = 6;
    localparam int HourW  = 5;
    localparam int ByteW  = 8;
    localparam int IdxW   = 3;
    localparam int UntilW = 19;

    localparam logic [7:0] WildMask   = 8'hC0;
    localparam logic [7:0] LowSevenMask = 8'h7F;
    localparam logic [3:0] NibbleMask = 4'hF;

    localparam logic [11:0] SecPerHour  = 12'd3600;
    localparam logic signed [15:0] SecPerMin = 16'sd60;
    localparam logic signed [9:0] MinPerHourS = 10'sd60;
    localparam logic [7:0] HoursPerDay = 8'd24;

    typedef enum logic [IdxW-1:0] {
        REG_ALARM_SEC  = 3'd0,
        REG_ALARM_MIN  = 3'd1,
        REG_ALARM_HOUR = 3'd2,
        REG_BINARY     = 3'd3,
        REG_HOUR24     = 3'd4,
        REG_SET_MODE   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] wake_sec;
        logic [7:0] wake_min;
        logic [6:0] wake_hour;
        logic       wild_sec;
        logic       wild_min;
        logic       wild_hour;
        logic       set_mode;
    } cfg_t;

    typedef struct packed {
        logic              armed;
        logic signed [7:0] hours;
        logic signed [9:0] minutes;
        logic signed [9:0] seconds;
    } sel_t;

    typedef struct packed {
        logic               armed;
        logic signed [19:0] hour_term;
        logic signed [15:0] min_term;
        logic signed [9:0]  seconds;
    } scale_t;

    typedef struct packed {
        logic              armed;
        logic [UntilW-1:0] seconds_until;
    } res_t;

    function automatic logic [7:0] decode_byte(input logic [7:0] b, input logic bin);
        logic [7:0] bcd;
        bcd = ({4'b0, b[7:4]} * 8'd10) + {4'b0, b[3:0] & NibbleMask};
        return bin ? b : bcd;
    endfunction

    function automatic logic [6:0] decode_hour(input logic [7:0] b, input logic bin,
                                               input logic h24);
        logic [7:0]  full;
        logic [6:0]  h;
        logic [13:0] prod;
        logic [3:0]  quot;
        logic [6:0]  rem;
        full = decode_byte(b & LowSevenMask, bin);
        h    = full[6:0];
        prod = {7'b0, h} * 14'd43;
        quot = prod[12:9];
        rem  = h - ({3'b0, quot} * 7'd12);
        if (h24)
        begin
            return h;
        end
        return rem + (b[7] ? 7'd12 : 7'd0);
    endfunction

    function automatic logic is_wild(input logic [7:0] b);
        return (b & WildMask) == WildMask;
    endfunction

endpackage

@@ rtl/core/rtc_alarm_countdown.sv @@
// ----------------------------------------------------------------------------
// rtc_alarm_countdown: seconds remaining until the next RTC alarm match.
// Each input transaction passes the select, scale and sum registers in turn.
// The three pipeline registers take one transaction per cycle unless out_ready stalls them.
// Reset empties the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module rtc_alarm_countdown
    import rac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IdxW-1:0]   cfg_index,
    input  logic [ByteW-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SecW-1:0]   now_second,
    input  logic [MinW-1:0]   now_minute,
    input  logic [HourW-1:0]  now_hour,
    input  logic              alarm_pending,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              armed,
    output logic [UntilW-1:0] seconds_until
);

    cfg_t   cfg;
    sel_t   sel_data;
    scale_t scale_data;
    res_t   res_data;
    logic   sel_valid, sel_ready;
    logic   scale_valid, scale_ready;

    rac_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rac_select u_select (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_second    (now_second),
        .now_minute    (now_minute),
        .now_hour      (now_hour),
        .alarm_pending (alarm_pending),
        .out_valid     (sel_valid),
        .out_ready     (sel_ready),
        .out_data      (sel_data)
    );

    rac_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_data   (sel_data),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale_data)
    );

    rac_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scale_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res_data)
    );

    assign armed         = res_data.armed;
    assign seconds_until = res_data.seconds_until;

endmodule

@@ rtl/core/rac_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rac_cfg_regs: configuration registers and decoded alarm values.
// The decoded alarm time is registered together with the raw bytes.
// ----------------------------------------------------------------------------
module rac_cfg_regs
    import rac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [ByteW-1:0] cfg_data,
    output cfg_t             cfg
);

    logic [7:0] sec_byte_reg, sec_byte_next;
    logic [7:0] min_byte_reg, min_byte_next;
    logic [7:0] hour_byte_reg, hour_byte_next;
    logic       binary_reg, binary_next;
    logic       hour24_reg, hour24_next;
    logic       set_mode_reg, set_mode_next;
    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    always_comb
    begin
        sec_byte_next  = sec_byte_reg;
        min_byte_next  = min_byte_reg;
        hour_byte_next = hour_byte_reg;
        binary_next    = binary_reg;
        hour24_next    = hour24_reg;
        set_mode_next  = set_mode_reg;
        if (wr_en)
        begin
            unique case (cfg_index)
                REG_ALARM_SEC:  sec_byte_next  = cfg_data;
                REG_ALARM_MIN:  min_byte_next  = cfg_data;
                REG_ALARM_HOUR: hour_byte_next = cfg_data;
                REG_BINARY:     binary_next    = cfg_data[0];
                REG_HOUR24:     hour24_next    = cfg_data[0];
                REG_SET_MODE:   set_mode_next  = cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cfg_next.wake_sec  = decode_byte(sec_byte_next, binary_next);
        cfg_next.wake_min  = decode_byte(min_byte_next, binary_next);
        cfg_next.wake_hour = decode_hour(hour_byte_next, binary_next, hour24_next);
        cfg_next.wild_sec  = is_wild(sec_byte_next);
        cfg_next.wild_min  = is_wild(min_byte_next);
        cfg_next.wild_hour = is_wild(hour_byte_next);
        cfg_next.set_mode  = set_mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_byte_reg  <= '0;
            min_byte_reg  <= '0;
            hour_byte_reg <= '0;
            binary_reg    <= 1'b0;
            hour24_reg    <= 1'b1;
            set_mode_reg  <= 1'b0;
            cfg_reg       <= '0;
        end
        else
        begin
            sec_byte_reg  <= sec_byte_next;
            min_byte_reg  <= min_byte_next;
            hour_byte_reg <= hour_byte_next;
            binary_reg    <= binary_next;
            hour24_reg    <= hour24_next;
            set_mode_reg  <= set_mode_next;
            cfg_reg       <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/rac_select.sv @@
// ----------------------------------------------------------------------------
// rac_select: first pipeline stage.
// Compares the current time against the alarm and picks the hour, minute
// and second terms of the countdown.
// ----------------------------------------------------------------------------
module rac_select
    import rac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SecW-1:0]  now_second,
    input  logic [MinW-1:0]  now_minute,
    input  logic [HourW-1:0] now_hour,
    input  logic             alarm_pending,
    output logic             out_valid,
    input  logic             out_ready,
    output sel_t             out_data
);

    logic              valid_reg;
    sel_t              data_reg, data_next;
    logic signed [9:0] cs, cm, as_s, am_s, sec_add, sec_wrap;
    logic [7:0]        ch8, ah8, hours, day_hours;

    always_comb
    begin
        cs        = signed'({4'b0, now_second});
        cm        = signed'({4'b0, now_minute});
        as_s      = signed'({2'b0, cfg.wake_sec});
        am_s      = signed'({2'b0, cfg.wake_min});
        ch8       = {3'b0, now_hour};
        ah8       = {1'b0, cfg.wake_hour};
        sec_add   = cfg.wild_sec ? 10'sd0 : as_s;
        sec_wrap  = (cs < as_s) ? (as_s - cs) : (as_s + MinPerHourS - cs);
        hours     = (ch8 < ah8) ? (ah8 - ch8) : (ah8 + HoursPerDay - ch8);
        day_hours = cfg.wild_hour ? 8'd1 : HoursPerDay;

        data_next.armed   = !alarm_pending && !cfg.set_mode;
        data_next.hours   = '0;
        data_next.minutes = '0;
        data_next.seconds = '0;

        priority if (cfg.wild_hour || (ch8 == ah8))
        begin
            priority if (cfg.wild_min)
            begin
                data_next.seconds = cfg.wild_sec ? 10'sd1 : sec_wrap;
            end
            else if (cm < am_s)
            begin
                data_next.minutes = am_s - cm;
                data_next.seconds = sec_add - cs;
            end
            else if (cm == am_s)
            begin
                priority if (cfg.wild_sec)
                begin
                    data_next.seconds = 10'sd1;
                end
                else if (cs < as_s)
                begin
                    data_next.seconds = as_s - cs;
                end
                else
                begin
                    data_next.hours   = day_hours;
                    data_next.seconds = as_s - cs;
                end
            end
            else if (cfg.wild_hour)
            begin
                data_next.minutes = am_s + MinPerHourS - cm;
                data_next.seconds = sec_add - cs;
            end
            else
            begin
                data_next.hours   = HoursPerDay;
                data_next.minutes = am_s - cm;
                data_next.seconds = sec_add - cs;
            end
        end
        else
        begin
            data_next.hours   = hours;
            data_next.minutes = cfg.wild_min ? (10'sd0 - cm) : (am_s - cm);
            data_next.seconds = sec_add - cs;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/rac_scale.sv @@
// ----------------------------------------------------------------------------
// rac_scale: second pipeline stage.
// Scales the hour term to seconds and the minute term to seconds.
// ----------------------------------------------------------------------------
module rac_scale
    import rac_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  sel_t   in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output scale_t out_data
);

    logic   valid_reg;
    scale_t data_reg, data_next;

    always_comb
    begin
        data_next.armed     = in_data.armed;
        data_next.hour_term = signed'({{12{in_data.hours[7]}}, in_data.hours})
                            * signed'({8'b0, SecPerHour});
        data_next.min_term  = signed'({{6{in_data.minutes[9]}}, in_data.minutes}) * SecPerMin;
        data_next.seconds   = in_data.seconds;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/rac_sum.sv @@
// ----------------------------------------------------------------------------
// rac_sum: third pipeline stage and output register.
// Adds the scaled terms, clamps a negative count to zero and drops the
// count when no alarm is scheduled.
// ----------------------------------------------------------------------------
module rac_sum
    import rac_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  scale_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output res_t   out_data
);

    logic               valid_reg;
    res_t               data_reg, data_next;
    logic signed [21:0] total;

    always_comb
    begin
        total = signed'({{2{in_data.hour_term[19]}}, in_data.hour_term})
              + signed'({{6{in_data.min_term[15]}}, in_data.min_term})
              + signed'({{12{in_data.seconds[9]}}, in_data.seconds});
        data_next.armed = in_data.armed;
        if (!in_data.armed || total[21])
        begin
            data_next.seconds_until = '0;
        end
        else
        begin
            data_next.seconds_until = total[UntilW-1:0];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/rac_checker.sv @@
// ----------------------------------------------------------------------------
// rac_checker: port-level assertions for the alarm countdown block.
// Bound to the top level; it only observes the ports.
// ----------------------------------------------------------------------------
`include "rtc_alarm_countdown_assert.svh"

module rac_checker
    import rac_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              alarm_pending,
    input logic              out_valid,
    input logic              out_ready,
    input logic              armed,
    input logic [UntilW-1:0] seconds_until
);

    // A result without a schedule never carries a count.
    `RAC_ASSERT_NOW(a_idle_count_zero, out_valid && !armed, seconds_until == '0, "count while not armed")

    // With out_ready held, an accepted transaction reaches the output.
    `RAC_ASSERT_NEXT(a_latency, in_valid && in_ready ##1 out_ready ##1 out_ready, out_valid, "result late")

    // A pending alarm flag always yields an unarmed result.
    `RAC_ASSERT_NEXT(a_pending_unarmed, in_valid && in_ready && alarm_pending ##1 out_ready ##1 out_ready, out_valid && !armed, "pending alarm armed")

    // A stalled result holds.
    `RAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(armed) && $stable(seconds_until), "stalled result changed")

endmodule

bind rtc_alarm_countdown rac_checker u_rac_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench for the RTC alarm countdown block.
// Time samples go through a valid/ready driver with random gaps, and the
// result side stalls at random and at times holds off for a long stretch.
// The alarm and mode registers are reprogrammed between phases while the
// block is idle. Every countdown is checked against a behavioral predictor.
// ---------------------------------------------------------------------------
module tb_top;
    import rac_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_SAMPLES = 122;

    typedef struct packed {
        logic [SecW-1:0]  second;
        logic [MinW-1:0]  minute;
        logic [HourW-1:0] hour;
        logic             pending;
    } time_sample_t;

    typedef struct packed {
        logic              armed;
        logic [UntilW-1:0] seconds;
    } countdown_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IdxW-1:0]   cfg_index = '0;
    logic [ByteW-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [SecW-1:0]   now_second = '0;
    logic [MinW-1:0]   now_minute = '0;
    logic [HourW-1:0]  now_hour = '0;
    logic              alarm_pending = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              armed;
    logic [UntilW-1:0] seconds_until;

    logic [7:0] wake_sec_reg = 8'h00;
    logic [7:0] wake_min_reg = 8'h00;
    logic [7:0] wake_hour_reg = 8'h00;
    logic       binary_reg = 1'b0;
    logic       hour24_reg = 1'b1;
    logic       set_mode_reg = 1'b0;

    time_sample_t time_samples[$];
    countdown_t   expected_countdowns[$];
    time_sample_t next_sample;
    countdown_t   wanted;

    logic idle_on = 1'b1;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   holds_done = 0;
    int   samples_sent = 0;
    int   cycle_count = 0;
    int   mismatch_count = 0;

    rtc_alarm_countdown dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_second    (now_second),
        .now_minute    (now_minute),
        .now_hour      (now_hour),
        .alarm_pending (alarm_pending),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .armed         (armed),
        .seconds_until (seconds_until)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int alarm_value(logic [7:0] b);
        return binary_reg ? int'(b) : int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic int wake_hour_value(logic [7:0] b);
        int h;
        h = alarm_value(b & 8'h7F);
        if (!hour24_reg)
        begin
            h = h % 12;
            if (b[7])
                h += 12;
        end
        return h;
    endfunction

    function automatic logic matches_any(logic [7:0] b);
        return b[7:6] == 2'b11;
    endfunction

    function automatic countdown_t predict_countdown(time_sample_t t);
        countdown_t r;
        int   cs, cm, ch, as, am, ah, extra, span_min, hours, n;
        logic any_s, any_m, any_h;
        cs = int'(t.second);
        cm = int'(t.minute);
        ch = int'(t.hour);
        any_s = matches_any(wake_sec_reg);
        any_m = matches_any(wake_min_reg);
        any_h = matches_any(wake_hour_reg);
        as = alarm_value(wake_sec_reg);
        am = alarm_value(wake_min_reg);
        ah = wake_hour_value(wake_hour_reg);
        extra = any_s ? 0 : as;
        span_min = any_h ? 60 : 1440;
        r = '0;
        if (t.pending || set_mode_reg)
            return r;
        if (any_h || ch == ah)
        begin
            if (any_m)
                n = any_s ? 1 : (cs < as ? as - cs : as + 60 - cs);
            else if (cm < am)
                n = (am - cm) * 60 - cs + extra;
            else if (cm == am)
                n = any_s ? 1 : (cs < as ? as - cs : span_min * 60 + as - cs);
            else
                n = (am + span_min - cm) * 60 - cs + extra;
        end
        else
        begin
            hours = (ch < ah) ? ah - ch : ah + 24 - ch;
            n = hours * 3600 - cm * 60 - cs + extra + (any_m ? 0 : am * 60);
        end
        r.armed = 1'b1;
        r.seconds = (n < 0) ? '0 : UntilW'(n);
        return r;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] encode_alarm(int v, logic bin);
        return bin ? 8'(v) : {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic logic [7:0] pick_alarm_byte(int limit, logic bin);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 8'hC0 | 8'($urandom_range(0, 63));
        if (r < 8)
            return encode_alarm($urandom_range(0, limit - 1), bin);
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic time_sample_t random_sample();
        time_sample_t t;
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            t.second = SecW'($urandom_range(0, 63));
            t.minute = MinW'($urandom_range(0, 63));
            t.hour   = HourW'($urandom_range(0, 31));
        end
        else if (r < 45)
        begin
            t.hour   = HourW'(wake_hour_value(wake_hour_reg));
            t.minute = MinW'(alarm_value(wake_min_reg) + int'($urandom_range(0, 2)) - 1);
            t.second = SecW'(alarm_value(wake_sec_reg) + int'($urandom_range(0, 2)) - 1);
        end
        else
        begin
            t.second = SecW'($urandom_range(0, 59));
            t.minute = MinW'($urandom_range(0, 59));
            t.hour   = HourW'($urandom_range(0, 23));
        end
        t.pending = ($urandom_range(0, 9) == 0);
        return t;
    endfunction

    function automatic void queue_sample(int s, int m, int h, int p);
        time_samples.push_back(time_sample_t'({SecW'(s), MinW'(m), HourW'(h), 1'(p)}));
    endfunction

    task automatic write_register(cfg_index_t idx, logic [ByteW-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ALARM_SEC:  wake_sec_reg   = data;
            REG_ALARM_MIN:  wake_min_reg   = data;
            REG_ALARM_HOUR: wake_hour_reg  = data;
            REG_BINARY:     binary_reg     = data[0];
            REG_HOUR24:     hour24_reg     = data[0];
            REG_SET_MODE:   set_mode_reg   = data[0];
            default: ;
        endcase
    endtask

    task automatic program_alarm(logic [7:0] sec_b, logic [7:0] min_b, logic [7:0] hour_b,
                                 logic bin, logic h24, logic halt);
        write_register(REG_ALARM_SEC, sec_b);
        write_register(REG_ALARM_MIN, min_b);
        write_register(REG_ALARM_HOUR, hour_b);
        write_register(REG_BINARY, {7'($urandom_range(0, 127)), bin});
        write_register(REG_HOUR24, {7'($urandom_range(0, 127)), h24});
        write_register(REG_SET_MODE, {7'($urandom_range(0, 127)), halt});
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (time_samples.size() > 0 || in_valid || expected_countdowns.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Driver: offers queued time samples, with random gaps between transactions.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_countdowns.push_back(predict_countdown(
                    time_sample_t'({now_second, now_minute, now_hour, alarm_pending})));
                samples_sent <= samples_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (time_samples.size() > 0)
                begin
                    next_sample = time_samples.pop_front();
                    now_second    <= next_sample.second;
                    now_minute    <= next_sample.minute;
                    now_hour      <= next_sample.hour;
                    alarm_pending <= next_sample.pending;
                    in_valid      <= 1'b1;
                    gap_left = idle_on ? idle_length() : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long result hold-off, started twice while the sender keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && samples_sent >= 300 + holds_done * 900)
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Monitor: checks each result transaction and stalls the result side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_countdowns.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual armed=%0b %0d",
                             $time, armed, seconds_until);
                    mismatch_count++;
                end
                else
                begin
                    wanted = expected_countdowns.pop_front();
                    if (armed !== wanted.armed)
                    begin
                        $display("%0t ns: armed mismatch, expected %0b actual %0b",
                                 $time, wanted.armed, armed);
                        mismatch_count++;
                    end
                    if (seconds_until !== wanted.seconds)
                    begin
                        $display("%0t ns: seconds_until mismatch, expected %0d actual %0d",
                                 $time, wanted.seconds, seconds_until);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0)
                out_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on)
                    stall_left = idle_length();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int         p;
        logic       bin;
        logic       h24;
        logic [7:0] hour_byte;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: alarm at midnight, BCD, 24-hour.
        queue_sample(0, 0, 0, 0);
        queue_sample(59, 59, 23, 0);
        queue_sample(63, 63, 31, 0);
        queue_sample(0, 0, 0, 1);
        settle();

        program_alarm(8'h30, 8'h30, 8'h12, 1'b0, 1'b1, 1'b1);
        queue_sample(30, 30, 12, 0);
        settle();

        program_alarm(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
        queue_sample(0, 0, 0, 0);
        queue_sample(59, 59, 23, 0);
        settle();

        // Nibbles above nine in BCD alarm bytes.
        program_alarm(8'h5F, 8'hAB, 8'h3C, 1'b0, 1'b1, 1'b0);
        queue_sample(10, 20, 5, 0);
        queue_sample(63, 63, 31, 0);
        settle();

        program_alarm(8'h15, 8'h30, 8'h92, 1'b0, 1'b0, 1'b0);
        queue_sample(15, 30, 12, 0);
        queue_sample(0, 0, 12, 0);
        queue_sample(20, 45, 11, 0);
        settle();

        program_alarm(8'h00, 8'h3F, 8'hBF, 1'b1, 1'b0, 1'b0);
        queue_sample(0, 0, 15, 0);
        queue_sample(5, 5, 3, 0);
        settle();

        program_alarm(8'hC0, 8'h59, 8'hC5, 1'b0, 1'b1, 1'b0);
        queue_sample(0, 59, 7, 0);
        queue_sample(0, 10, 7, 0);
        queue_sample(30, 0, 7, 0);
        settle();

        program_alarm(8'h30, 8'hE0, 8'h08, 1'b0, 1'b1, 1'b0);
        queue_sample(10, 5, 8, 0);
        queue_sample(40, 5, 8, 0);
        queue_sample(10, 5, 9, 0);
        settle();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_on = (p % 5 != 2);
            bin = 1'($urandom_range(0, 1));
            h24 = 1'($urandom_range(0, 1));
            if (h24 || $urandom_range(0, 3) == 0)
                hour_byte = pick_alarm_byte(24, bin);
            else
                hour_byte = encode_alarm($urandom_range(1, 12), bin)
                            | (8'($urandom_range(0, 1)) << 7);
            program_alarm(pick_alarm_byte(60, bin), pick_alarm_byte(60, bin), hour_byte,
                          bin, h24, $urandom_range(0, 6) == 0);
            repeat (PHASE_SAMPLES) time_samples.push_back(random_sample());
            settle();
        end

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
